// ----- src/assert_macros.svh -----
// Assertion helpers for the two-class priority queue.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge out of reset.
`define TCPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge out of reset.
`define TCPQ_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define TCPQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define TCPQ_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ----- src/tcpq_pkg.sv -----
package tcpq_pkg;

  // Ring geometry (entries per class) and stored value width
  localparam int CLASS_DEPTH = 16;
  localparam int VALUE_BITS  = 16;

  localparam int PTR_W = $clog2(CLASS_DEPTH);
  localparam int CNT_W = $clog2(CLASS_DEPTH + 1);

  // Port field widths
  localparam int DATA_W   = 16;
  localparam int STATUS_W = 2;

  localparam logic signed [DATA_W-1:0] THR_RESET = 16'sd60;

  // Request opcodes
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef logic signed [DATA_W-1:0]     data_t;
  typedef logic signed [VALUE_BITS-1:0] val_t;
  typedef logic [PTR_W-1:0]             ptr_t;
  typedef logic [CNT_W-1:0]             cnt_t;

  typedef struct packed {
    logic push;
    logic pop;
  } ring_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    ptr_t head;
    ptr_t tail;
  } ring_stat_t;

  // Port value to stored value (sign-extend or truncate)
  function automatic val_t to_store(data_t d);
    return val_t'(d);
  endfunction

  // Stored value back to port width (sign-extend or truncate)
  function automatic data_t from_store(val_t v);
    return data_t'(v);
  endfunction

endpackage

// ----- src/tcpq_if.sv -----
interface tcpq_in_if;
  logic                 valid;
  logic                 ready;
  logic                 func;
  tcpq_pkg::data_t      item_value;

  modport source (output valid, output func, output item_value, input ready);
  modport sink   (input valid, input func, input item_value, output ready);
endinterface

interface tcpq_out_if;
  logic                            valid;
  logic                            ready;
  logic [tcpq_pkg::STATUS_W-1:0]   status;
  tcpq_pkg::data_t                 removed_value;

  modport source (output valid, output status, output removed_value, input ready);
  modport sink   (input valid, input status, input removed_value, output ready);
endinterface

interface tcpq_cfg_if;
  logic            valid;
  logic            ready;
  tcpq_pkg::data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/tcpq_ram.sv -----
module tcpq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ----- src/tcpq_ring_ctl.sv -----
`include "assert_macros.svh"

module tcpq_ring_ctl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tcpq_pkg::ring_cmd_t    cmd,
  output tcpq_pkg::ring_stat_t   stat
);

  localparam tcpq_pkg::ptr_t PTR_LAST = tcpq_pkg::PTR_W'(tcpq_pkg::CLASS_DEPTH - 1);
  localparam tcpq_pkg::cnt_t CNT_FULL = tcpq_pkg::CNT_W'(tcpq_pkg::CLASS_DEPTH);

  tcpq_pkg::ptr_t head_r, head_nxt;
  tcpq_pkg::ptr_t tail_r, tail_nxt;
  tcpq_pkg::cnt_t count_r, count_nxt;

  // caller never pushes and pops in the same cycle
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (cmd.push) begin
      tail_nxt  = (tail_r == PTR_LAST) ? '0 : tail_r + 1'b1;
      count_nxt = count_r + 1'b1;
    end else if (cmd.pop) begin
      head_nxt  = (head_r == PTR_LAST) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CNT_FULL);
  assign stat.head  = head_r;
  assign stat.tail  = tail_r;

  `TCPQ_NEVER(a_no_overflow, clk, rst_n, count_r > CNT_FULL, "ring count beyond depth")
  `TCPQ_ASSERT(a_ptr_match, clk, rst_n, (stat.empty || stat.full) |-> head_r == tail_r, "bad ptrs")
  `TCPQ_NEVER(a_push_pop, clk, rst_n, cmd.push && cmd.pop, "push and pop together")

endmodule

// ----- src/two_class_priority_queue_top.sv -----
// Two-class strict-priority queue, one request per cycle sustained while the output is not stalled.
// Result path: the RAM read shares the accepting edge with stage 1; the output reg loads from
// stage 1 when free. Throughput: 1 request/cycle unless the output stalls; each request
// touches at most one ring head or tail in one RAM port.
// Reset (rst_n low, synchronous): ring pointers and counts cleared, threshold back to 60,
// pipeline and output emptied. Ring RAMs are not cleared; no entry is read before written.
`include "assert_macros.svh"

module two_class_priority_queue_top (
  input  logic               clk,
  input  logic               rst_n,
  tcpq_in_if.sink            in_ch,
  tcpq_out_if.source         out_ch,
  tcpq_cfg_if.sink           cfg_ch
);

  // which RAM feeds the removed value in stage 1
  localparam logic [1:0] SEL_NONE = 2'd0;
  localparam logic [1:0] SEL_HIGH = 2'd1;
  localparam logic [1:0] SEL_LOW  = 2'd2;

  // ---------------------------------------------------------------
  // Threshold register; the user writes it only while the queue is idle, the block does not enforce this
  // ---------------------------------------------------------------
  tcpq_pkg::data_t thr_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= tcpq_pkg::THR_RESET;
    end else if (cfg_ch.valid) begin
      thr_r <= cfg_ch.data;
    end
  end

  // ---------------------------------------------------------------
  // Handshake and pipeline control
  // Stage 1 holds the request whose RAM read is in flight; the
  // output register parts it from the consumer.
  // ---------------------------------------------------------------
  logic                           s1_valid_r;
  logic [tcpq_pkg::STATUS_W-1:0]  s1_status_r;
  logic [1:0]                     s1_sel_r;

  logic                           out_valid_r;
  logic [tcpq_pkg::STATUS_W-1:0]  out_status_r;
  tcpq_pkg::data_t                out_value_r;

  logic out_free;
  logic s1_move;
  logic acc;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_move     = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign acc         = in_ch.valid && in_ch.ready;

  // ---------------------------------------------------------------
  // Class decision and ring commands
  // ---------------------------------------------------------------
  tcpq_pkg::ring_stat_t hi_stat, lo_stat;
  tcpq_pkg::ring_cmd_t  hi_cmd, lo_cmd;

  logic is_ins;
  logic is_high;
  logic ins_full;
  logic q_empty;

  assign is_ins   = (in_ch.func == tcpq_pkg::FUNC_INSERT);
  assign is_high  = (in_ch.item_value >= thr_r);           // signed compare
  assign ins_full = is_high ? hi_stat.full : lo_stat.full;
  assign q_empty  = hi_stat.empty && lo_stat.empty;

  // strict priority: low ring pops only when high ring is empty
  assign hi_cmd.push = acc && is_ins && is_high && !hi_stat.full;
  assign lo_cmd.push = acc && is_ins && !is_high && !lo_stat.full;
  assign hi_cmd.pop  = acc && !is_ins && !hi_stat.empty;
  assign lo_cmd.pop  = acc && !is_ins && hi_stat.empty && !lo_stat.empty;

  tcpq_ring_ctl u_hi_ctl (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (hi_cmd),
    .stat (hi_stat)
  );

  tcpq_ring_ctl u_lo_ctl (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (lo_cmd),
    .stat (lo_stat)
  );

  // ---------------------------------------------------------------
  // Ring storage: insert writes at tail, remove reads at head.
  // A read and a write to the same entry never share a cycle, and a
  // value written in one cycle is visible to any later read.
  // ---------------------------------------------------------------
  tcpq_pkg::val_t wr_val;
  tcpq_pkg::val_t hi_rdata, lo_rdata;

  assign wr_val = tcpq_pkg::to_store(in_ch.item_value);

  tcpq_ram #(
    .DEPTH(tcpq_pkg::CLASS_DEPTH),
    .WIDTH(tcpq_pkg::VALUE_BITS)
  ) u_hi_ram (
    .clk    (clk),
    .we     (hi_cmd.push),
    .waddr  (hi_stat.tail),
    .wdata  (wr_val),
    .re     (hi_cmd.pop),
    .raddr  (hi_stat.head),
    .rdata_r(hi_rdata)
  );

  tcpq_ram #(
    .DEPTH(tcpq_pkg::CLASS_DEPTH),
    .WIDTH(tcpq_pkg::VALUE_BITS)
  ) u_lo_ram (
    .clk    (clk),
    .we     (lo_cmd.push),
    .waddr  (lo_stat.tail),
    .wdata  (wr_val),
    .re     (lo_cmd.pop),
    .raddr  (lo_stat.head),
    .rdata_r(lo_rdata)
  );

  // ---------------------------------------------------------------
  // Stage 1: status and RAM select wait here for the read data.
  // While stalled, no new request is taken, so RAM read data holds.
  // ---------------------------------------------------------------
  logic [tcpq_pkg::STATUS_W-1:0] acc_status;
  logic [1:0]                    acc_sel;

  always_comb begin
    acc_sel = SEL_NONE;
    if (is_ins) begin
      acc_status = ins_full ? tcpq_pkg::ST_FULL : tcpq_pkg::ST_DONE;
    end else begin
      acc_status = q_empty ? tcpq_pkg::ST_EMPTY : tcpq_pkg::ST_DONE;
      if (!hi_stat.empty) begin
        acc_sel = SEL_HIGH;
      end else if (!lo_stat.empty) begin
        acc_sel = SEL_LOW;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_status_r <= acc_status;
      s1_sel_r    <= acc_sel;
    end
  end

  // ---------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------
  tcpq_pkg::data_t s1_value;

  always_comb begin
    unique case (s1_sel_r)
      SEL_HIGH: s1_value = tcpq_pkg::from_store(hi_rdata);
      SEL_LOW:  s1_value = tcpq_pkg::from_store(lo_rdata);
      default:  s1_value = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_status_r <= s1_status_r;
      out_value_r  <= s1_value;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.removed_value = out_value_r;

  // ---------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------
  logic out_fail;
  logic s1_stall;

  assign out_fail = out_valid_r && (out_status_r != tcpq_pkg::ST_DONE);
  assign s1_stall = s1_valid_r && !out_free;

  `TCPQ_NEVER(a_single_pop, clk, rst_n, hi_cmd.pop && lo_cmd.pop, "both rings popped at once")
  `TCPQ_ASSERT(a_strict_prio, clk, rst_n, lo_cmd.pop |-> hi_stat.empty, "low popped ahead of high")
  `TCPQ_ASSERT(a_fail_zero, clk, rst_n, out_fail |-> (out_value_r == '0), "failed with value")
  `TCPQ_ASSERT(a_s1_hold, clk, rst_n, s1_stall |=> (s1_valid_r && $stable(s1_sel_r)), "s1 lost")

endmodule

// ----- sim/tcpq_result_checker.sv -----
module tcpq_result_checker (
  input  logic clk,
  input  logic rst_n,
  tcpq_in_if   in_ch,
  tcpq_out_if  out_ch,
  tcpq_cfg_if  cfg_ch,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [tcpq_pkg::STATUS_W-1:0] status;
    tcpq_pkg::data_t               removed_value;
  } queue_result_t;

  // Shadow copy of both class rings and the threshold
  tcpq_pkg::val_t  high_ring [tcpq_pkg::CLASS_DEPTH];
  tcpq_pkg::val_t  low_ring  [tcpq_pkg::CLASS_DEPTH];
  int              high_head, high_cnt;
  int              low_head, low_cnt;
  tcpq_pkg::data_t threshold;

  queue_result_t pending_results[$];

  // Applies one request to the shadow rings, returns the result it must produce
  function automatic queue_result_t serve_request(logic op, tcpq_pkg::data_t value);
    queue_result_t r;
    r.status        = tcpq_pkg::ST_DONE;
    r.removed_value = '0;
    if (op == tcpq_pkg::FUNC_INSERT) begin
      if (value >= threshold) begin
        if (high_cnt == tcpq_pkg::CLASS_DEPTH) begin
          r.status = tcpq_pkg::ST_FULL;
        end else begin
          high_ring[(high_head + high_cnt) % tcpq_pkg::CLASS_DEPTH] = tcpq_pkg::val_t'(value);
          high_cnt++;
        end
      end else begin
        if (low_cnt == tcpq_pkg::CLASS_DEPTH) begin
          r.status = tcpq_pkg::ST_FULL;
        end else begin
          low_ring[(low_head + low_cnt) % tcpq_pkg::CLASS_DEPTH] = tcpq_pkg::val_t'(value);
          low_cnt++;
        end
      end
    end else if (high_cnt != 0) begin
      r.removed_value = tcpq_pkg::data_t'(high_ring[high_head]);
      high_head       = (high_head + 1) % tcpq_pkg::CLASS_DEPTH;
      high_cnt--;
    end else if (low_cnt != 0) begin
      r.removed_value = tcpq_pkg::data_t'(low_ring[low_head]);
      low_head        = (low_head + 1) % tcpq_pkg::CLASS_DEPTH;
      low_cnt--;
    end else begin
      r.status = tcpq_pkg::ST_EMPTY;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    queue_result_t want;
    if (!rst_n) begin
      high_head = 0;
      high_cnt  = 0;
      low_head  = 0;
      low_cnt   = 0;
      threshold = tcpq_pkg::THR_RESET;
      pending_results.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        threshold = cfg_ch.data;
      end
      if (in_ch.valid && in_ch.ready) begin
        pending_results.push_back(serve_request(in_ch.func, in_ch.item_value));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, actual status %0d value %0d",
                   $time, out_ch.status, out_ch.removed_value);
        end else begin
          want = pending_results.pop_front();
          if (out_ch.status !== want.status) begin
            fail_count++;
            $display("%0t: status expected %0d actual %0d",
                     $time, want.status, out_ch.status);
          end
          if (out_ch.removed_value !== want.removed_value) begin
            fail_count++;
            $display("%0t: removed_value expected %0d actual %0d",
                     $time, want.removed_value, out_ch.removed_value);
          end
        end
      end
    end
    pending = pending_results.size();
  end

endmodule

// ----- sim/tb_two_class_priority_queue_top.sv -----
module tb_two_class_priority_queue_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam tcpq_pkg::data_t VAL_MIN        = 16'sh8000;
  localparam tcpq_pkg::data_t VAL_MAX        = 16'sh7FFF;
  localparam int              HOLD_CYCLES    = 150;   // receiver back-pressure stretch
  localparam int              WATCHDOG_LIMIT = 2000;  // cycles with no handshake anywhere
  localparam int              PHASE_REQS     = 115;

  logic clk;
  logic rst_n;

  tcpq_in_if  in_ch ();
  tcpq_out_if out_ch ();
  tcpq_cfg_if cfg_ch ();

  two_class_priority_queue_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  int checker_fails;
  int results_pending;

  tcpq_result_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .fail_count (checker_fails),
    .pending    (results_pending)
  );

  // Idle percentages per side; dropped to zero for the no-gap phase
  int              send_idle_pct = 28;
  int              recv_idle_pct = 28;
  bit              hold_off_req;  // set by stimulus, cleared by the receiver after its stall
  tcpq_pkg::data_t cur_thr;       // threshold last written, used to aim values at the boundary

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Result side: random ready at each falling edge, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: any handshake (or reset) restarts the count
  initial begin
    int idle_run;
    idle_run = 0;
    while (idle_run < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_run = 0;
      end else begin
        idle_run++;
      end
    end
    $display("Regression FAIL");
    $finish;
  end

  // Offers one request, with random idle cycles ahead of it. Called and returns at a
  // falling edge; valid is left high so back-to-back requests never drop it.
  task automatic send_req(input logic op, input tcpq_pkg::data_t value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.func       <= op;
    in_ch.item_value <= value;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Threshold write, only with no results outstanding and the pipeline flushed
  task automatic write_threshold(input tcpq_pkg::data_t value);
    in_ch.valid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);   // margin after the last result is out
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    cur_thr = value;
  endtask

  // Mix of full-range values, values right around the threshold, and extremes
  function automatic tcpq_pkg::data_t pick_value(input tcpq_pkg::data_t thr);
    int t;
    case ($urandom_range(9)) inside
      [0:3]: return tcpq_pkg::data_t'($urandom);
      [4:7]: begin
        t = int'(thr) + int'($urandom_range(8)) - 4;
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;
        return tcpq_pkg::data_t'(t);
      end
      default: begin
        case ($urandom_range(4))
          0:       return VAL_MIN;
          1:       return VAL_MAX;
          2:       return '0;
          3:       return '1;
          default: return thr;
        endcase
      end
    endcase
  endfunction

  task automatic run_random(input int n, input int insert_pct);
    repeat (n) begin
      if ($urandom_range(99) < insert_pct) begin
        send_req(tcpq_pkg::FUNC_INSERT, pick_value(cur_thr));
      end else begin
        // value field is don't-care on remove; randomize it anyway
        send_req(tcpq_pkg::FUNC_REMOVE, tcpq_pkg::data_t'($urandom));
      end
    end
  endtask

  initial begin
    tcpq_pkg::data_t phase_thr [8];
    int              phase_ins [8];
    tcpq_pkg::data_t thr;

    phase_thr = '{tcpq_pkg::THR_RESET, VAL_MIN, VAL_MAX, 16'sd0, 16'sd0, 16'sd0, -16'sd1,
                  tcpq_pkg::THR_RESET};
    phase_ins = '{50, 80, 35, 65, 90, 20, 55, 60};

    // Everything known from time zero; reset held low first
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.func       = tcpq_pkg::FUNC_INSERT;
    in_ch.item_value = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.data      = '0;
    hold_off_req     = 1'b0;
    cur_thr          = tcpq_pkg::THR_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // --- Directed: reset threshold of 60 ---
    send_req(tcpq_pkg::FUNC_REMOVE, '0);          // remove from an empty queue
    send_req(tcpq_pkg::FUNC_INSERT, 16'sd60);     // exactly at threshold -> high class
    send_req(tcpq_pkg::FUNC_INSERT, 16'sd59);     // just below -> low class
    send_req(tcpq_pkg::FUNC_INSERT, VAL_MAX);
    send_req(tcpq_pkg::FUNC_INSERT, VAL_MIN);
    send_req(tcpq_pkg::FUNC_INSERT, 16'sd0);
    send_req(tcpq_pkg::FUNC_INSERT, -16'sd1);
    // high class drains first (60, max), then low in arrival order
    repeat (6) send_req(tcpq_pkg::FUNC_REMOVE, VAL_MAX);
    send_req(tcpq_pkg::FUNC_REMOVE, VAL_MIN);     // empty again

    // Threshold at the minimum: every value is high class
    write_threshold(VAL_MIN);
    send_req(tcpq_pkg::FUNC_INSERT, VAL_MIN);
    send_req(tcpq_pkg::FUNC_INSERT, VAL_MAX);
    repeat (2) send_req(tcpq_pkg::FUNC_REMOVE, '0);

    // Threshold at the maximum: only the max value is high class
    write_threshold(VAL_MAX);
    send_req(tcpq_pkg::FUNC_INSERT, 16'sd32766);
    send_req(tcpq_pkg::FUNC_INSERT, VAL_MIN);
    send_req(tcpq_pkg::FUNC_INSERT, VAL_MAX);
    repeat (3) send_req(tcpq_pkg::FUNC_REMOVE, '0);

    // --- Back-pressure: receiver stalls at the start, and the high class overfills ---
    write_threshold(tcpq_pkg::THR_RESET);
    hold_off_req = 1'b1;
    repeat (20) send_req(tcpq_pkg::FUNC_INSERT, tcpq_pkg::data_t'(60 + $urandom_range(20000)));
    // 16 come back, then the queue runs dry
    repeat (22) send_req(tcpq_pkg::FUNC_REMOVE, tcpq_pkg::data_t'($urandom));

    // --- Random phases, each at its own threshold and insert/remove mix ---
    for (int p = 0; p < 8; p++) begin
      thr = (p == 4 || p == 5) ? tcpq_pkg::data_t'($urandom) : phase_thr[p];
      write_threshold(thr);
      if (p == 2) begin
        // long stretch with no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        send_idle_pct = 28;
        recv_idle_pct = 28;
      end
      run_random(PHASE_REQS, phase_ins[p]);
    end

    // Drain, then give the pipeline time to show any stray result
    in_ch.valid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    if (checker_fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
